// ===== design/bapst_pkg.sv =====
// ----------------------------------------------------------------------------
// bapst_pkg
// Shared types and constants for the button to pedal and steering block.
// ----------------------------------------------------------------------------
package bapst_pkg;

   // tick counter width default
   localparam int TICK_COUNT_WIDTH = 16;

   // configuration port geometry
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 3;

   // adjustment step and centering shift
   localparam logic [7:0] ADJ_STEP     = 8'd2;
   localparam int         RETURN_SHIFT = 4;

   // register reset values
   localparam logic [7:0]  PEDAL_MIN_RESET     = 8'd32;
   localparam logic [7:0]  PEDAL_MAX_RESET     = 8'd144;
   localparam logic [7:0]  STEER_MIN_RESET     = 8'd51;
   localparam logic [7:0]  STEER_MAX_RESET     = 8'd203;
   localparam logic [7:0]  STEER_CENTER_RESET  = 8'd128;
   localparam logic [15:0] DEBOUNCE_RESET      = 16'd400;
   localparam logic [15:0] REPEAT_DELAY_RESET  = 16'd6000;
   localparam logic [15:0] REPEAT_RATE_RESET   = 16'd620;

   // state reset values
   localparam logic [7:0] PEDAL_VALUE_RESET  = 8'd144;
   localparam logic [7:0] PEDAL_TARGET_RESET = 8'd32;
   localparam logic [7:0] STEER_VALUE_RESET  = 8'd128;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PEDAL_MIN    = 3'd0,
      CSR_PEDAL_MAX    = 3'd1,
      CSR_STEER_MIN    = 3'd2,
      CSR_STEER_MAX    = 3'd3,
      CSR_STEER_CENTER = 3'd4,
      CSR_DEBOUNCE     = 3'd5,
      CSR_REPEAT_DELAY = 3'd6,
      CSR_REPEAT_RATE  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  pedal_min;
      logic [7:0]  pedal_max;
      logic [7:0]  steer_min;
      logic [7:0]  steer_max;
      logic [7:0]  steer_center;
      logic [15:0] debounce_ticks;
      logic [15:0] repeat_delay_ticks;
      logic [15:0] repeat_rate_ticks;
   } cfg_type;

   typedef struct packed {
      logic accel;
      logic shift;
      logic brake;
      logic up;
      logic down;
      logic left;
      logic right;
   } btn_type;

   // raise target by one step, capped at max
   function automatic logic [7:0] target_raise(input logic [7:0] t, input logic [7:0] hi);
      logic [8:0] s;
      s = {1'b0, t} + {1'b0, ADJ_STEP};
      return (s > {1'b0, hi}) ? hi : s[7:0];
   endfunction

   // lower target by one step, stopping at min
   function automatic logic [7:0] target_lower(input logic [7:0] t, input logic [7:0] lo);
      logic [8:0] floor_v;
      floor_v = {1'b0, lo} + {1'b0, ADJ_STEP};
      return ({1'b0, t} >= floor_v) ? (t - ADJ_STEP) : lo;
   endfunction

endpackage

// ===== design/bapst_repeat.sv =====
// ----------------------------------------------------------------------------
// bapst_repeat
// Press and auto-repeat tracker for one target adjust button.
// ----------------------------------------------------------------------------
module bapst_repeat #(
   parameter int TICK_COUNT_WIDTH = bapst_pkg::TICK_COUNT_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        pressed,
   input  logic        armed,
   input  logic [15:0] delay_ticks,
   input  logic [15:0] rate_ticks,
   output logic        fire
);

   localparam int CW = (TICK_COUNT_WIDTH > 16) ? TICK_COUNT_WIDTH : 16;

   logic                        held_ff, held_in;
   logic                        rep_ff, rep_in;
   logic [TICK_COUNT_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic [TICK_COUNT_WIDTH-1:0] elapsed_inc;
   logic [15:0]                 thr;

   always_comb begin
      held_in     = held_ff;
      rep_in      = rep_ff;
      elapsed_in  = elapsed_ff;
      fire        = 1'b0;
      elapsed_inc = (&elapsed_ff) ? elapsed_ff : elapsed_ff + 1'b1;
      thr         = rep_ff ? rate_ticks : delay_ticks;
      if (pressed) begin
         if (!held_ff) begin
            fire       = armed;
            held_in    = 1'b1;
            rep_in     = 1'b0;
            elapsed_in = '0;
         end else if (armed && (CW'(elapsed_inc) >= CW'(thr))) begin
            fire       = 1'b1;
            rep_in     = 1'b1;
            elapsed_in = '0;
         end else begin
            elapsed_in = elapsed_inc;
         end
      end else begin
         held_in = 1'b0;
         rep_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= 1'b0;
         rep_ff     <= 1'b0;
         elapsed_ff <= '0;
      end else if (en) begin
         held_ff    <= held_in;
         rep_ff     <= rep_in;
         elapsed_ff <= elapsed_in;
      end
   end

endmodule

// ===== design/bapst_pedal.sv =====
// ----------------------------------------------------------------------------
// bapst_pedal
// Pedal target tracking, idle force and ramp, with up and down adjust.
// ----------------------------------------------------------------------------
module bapst_pedal #(
   parameter int TICK_COUNT_WIDTH = bapst_pkg::TICK_COUNT_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  bapst_pkg::cfg_type cfg,
   input  bapst_pkg::btn_type btn,
   output logic [7:0]         level_in,
   output logic               written_in
);

   logic       accel_held_ff;
   logic [7:0] value_ff, value_in;
   logic [7:0] target_ff, target_in;
   logic [7:0] target_edge;
   logic [7:0] value_edge;
   logic [7:0] target_up;
   logic [8:0] ramp;
   logic       up_fire, down_fire;

   bapst_repeat #(.TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)) u_up (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .pressed     (btn.up),
      .armed       (btn.accel),
      .delay_ticks (cfg.repeat_delay_ticks),
      .rate_ticks  (cfg.repeat_rate_ticks),
      .fire        (up_fire)
   );

   bapst_repeat #(.TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)) u_down (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .pressed     (btn.down),
      .armed       (btn.accel),
      .delay_ticks (cfg.repeat_delay_ticks),
      .rate_ticks  (cfg.repeat_rate_ticks),
      .fire        (down_fire)
   );

   always_comb begin
      target_edge = target_ff;
      value_edge  = value_ff;
      written_in  = 1'b0;
      ramp        = {1'b0, value_ff};
      // accelerate edges, idle force while released
      if (btn.accel) begin
         if (!accel_held_ff) begin
            target_edge = cfg.pedal_max;
         end
      end else if (accel_held_ff) begin
         target_edge = cfg.pedal_min;
      end else begin
         value_edge = (cfg.pedal_min > cfg.pedal_max) ? cfg.pedal_max : cfg.pedal_min;
         written_in = 1'b1;
      end
      // ramp toward target, capped at max
      value_in = value_edge;
      if (value_edge != target_edge) begin
         if (value_edge < target_edge) begin
            ramp = {1'b0, value_edge} + {1'b0, bapst_pkg::ADJ_STEP};
            if (ramp > {1'b0, target_edge}) begin
               ramp = {1'b0, target_edge};
            end
         end else if ({1'b0, value_edge} >=
                      ({1'b0, target_edge} + {1'b0, bapst_pkg::ADJ_STEP})) begin
            ramp = {1'b0, value_edge - bapst_pkg::ADJ_STEP};
         end else begin
            ramp = {1'b0, target_edge};
         end
         value_in   = (ramp > {1'b0, cfg.pedal_max}) ? cfg.pedal_max : ramp[7:0];
         written_in = 1'b1;
      end
      // adjust buttons move the target for the next tick
      target_up = up_fire ? bapst_pkg::target_raise(target_edge, cfg.pedal_max)
                          : target_edge;
      target_in = down_fire ? bapst_pkg::target_lower(target_up, cfg.pedal_min)
                            : target_up;
      level_in  = value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_held_ff <= 1'b0;
         value_ff      <= bapst_pkg::PEDAL_VALUE_RESET;
         target_ff     <= bapst_pkg::PEDAL_TARGET_RESET;
      end else if (en) begin
         accel_held_ff <= btn.accel;
         value_ff      <= value_in;
         target_ff     <= target_in;
      end
   end

endmodule

// ===== design/bapst_shift.sv =====
// ----------------------------------------------------------------------------
// bapst_shift
// Shift button debounce and toggle latch driving the shift pin.
// ----------------------------------------------------------------------------
module bapst_shift #(
   parameter int TICK_COUNT_WIDTH = bapst_pkg::TICK_COUNT_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic [15:0] debounce_ticks,
   input  logic        shift,
   output logic        pin_in
);

   localparam int CW = (TICK_COUNT_WIDTH > 16) ? TICK_COUNT_WIDTH : 16;

   logic                        raw_last_ff;
   logic [TICK_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                        confirmed_ff, confirmed_in;
   logic                        latch_ff, latch_in;
   logic                        pin_ff;

   always_comb begin
      confirmed_in = confirmed_ff;
      latch_in     = latch_ff;
      pin_in       = pin_ff;
      if (shift != raw_last_ff) begin
         count_in = '0;
      end else begin
         count_in = (&count_ff) ? count_ff : count_ff + 1'b1;
      end
      if ((CW'(count_in) == CW'(debounce_ticks)) && (shift != confirmed_ff)) begin
         confirmed_in = shift;
         if (shift) begin
            latch_in = ~latch_ff;
            pin_in   = ~latch_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_last_ff  <= 1'b0;
         count_ff     <= '0;
         confirmed_ff <= 1'b0;
         latch_ff     <= 1'b1;
         pin_ff       <= 1'b0;
      end else if (en) begin
         raw_last_ff  <= shift;
         count_ff     <= count_in;
         confirmed_ff <= confirmed_in;
         latch_ff     <= latch_in;
         pin_ff       <= pin_in;
      end
   end

endmodule

// ===== design/bapst_steer.sv =====
// ----------------------------------------------------------------------------
// bapst_steer
// Steering level stepping within limits and spring back to center.
// ----------------------------------------------------------------------------
module bapst_steer (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  bapst_pkg::cfg_type cfg,
   input  logic               left,
   input  logic               right,
   output logic [7:0]         level_in,
   output logic               written_in
);

   logic [7:0] value_ff;
   logic [7:0] after_right;
   logic [7:0] after_left;
   logic [7:0] lowered;
   logic [8:0] raised;
   logic [7:0] distance;
   logic [7:0] st;

   always_comb begin
      written_in = left | right;
      // right first, then left
      raised      = {1'b0, value_ff} + {1'b0, bapst_pkg::ADJ_STEP};
      after_right = right ? ((raised > {1'b0, cfg.steer_max}) ? cfg.steer_max : raised[7:0])
                          : value_ff;
      lowered     = ({1'b0, after_right} >=
                     ({1'b0, cfg.steer_min} + {1'b0, bapst_pkg::ADJ_STEP}))
                    ? (after_right - bapst_pkg::ADJ_STEP) : cfg.steer_min;
      after_left  = left ? ((lowered > cfg.steer_max) ? cfg.steer_max : lowered)
                         : after_right;
      // centering step is distance over sixteen, at least one
      distance = (value_ff > cfg.steer_center) ? (value_ff - cfg.steer_center)
                                               : (cfg.steer_center - value_ff);
      st       = distance >> bapst_pkg::RETURN_SHIFT;
      if (st == 8'd0) begin
         st = 8'd1;
      end
      level_in = after_left;
      if (!left && !right && (value_ff != cfg.steer_center)) begin
         written_in = 1'b1;
         if (distance <= st) begin
            level_in = cfg.steer_center;
         end else if (value_ff > cfg.steer_center) begin
            level_in = value_ff - st;
         end else begin
            level_in = value_ff + st;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= bapst_pkg::STEER_VALUE_RESET;
      end else if (en) begin
         value_ff <= level_in;
      end
   end

endmodule

// ===== design/button_to_analog_pedal_steer.sv =====
// ----------------------------------------------------------------------------
// button_to_analog_pedal_steer
// Turns seven button levels per tick into pedal and steering converter codes
// and the shift and brake pin levels.
// ----------------------------------------------------------------------------
// One item is one polling tick of the buttons; each item gives exactly one
// result. An item is taken into an input register, processed by the pedal,
// shift and steering logic, and its result lands in an output register, so
// a new item can be accepted every cycle unless rsp_stall holds the output
// register: throughput is one item per clock. A result reaches the outputs
// through the input register and then the output register. The pace is set
// by the tick update, a short chain of 9-bit adds and compares per channel
// plus a four-bit shift for centering.
// The output register holds a result while rsp_stall is high; the input
// register keeps accepting behind it until both are full. The configuration
// registers come out of reset with their default values, so no clearing pass
// is needed after reset. They are written through csr_write/csr_index/csr_data
// by the user, only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module button_to_analog_pedal_steer #(
   parameter int TICK_COUNT_WIDTH = bapst_pkg::TICK_COUNT_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration write port
   input  logic                                  csr_write,
   input  logic [bapst_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bapst_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   // tick items in
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_accel_button,
   input  logic                                  req_shift_button,
   input  logic                                  req_brake_button,
   input  logic                                  req_up_button,
   input  logic                                  req_down_button,
   input  logic                                  req_left_button,
   input  logic                                  req_right_button,
   // results out
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [7:0]                            rsp_pedal_level,
   output logic                                  rsp_pedal_written,
   output logic [7:0]                            rsp_steer_level,
   output logic                                  rsp_steer_written,
   output logic                                  rsp_shift_out,
   output logic                                  rsp_brake_out
);

   // configuration registers
   bapst_pkg::cfg_type cfg_ff;

   // input register
   logic               in_valid_ff;
   bapst_pkg::btn_type in_item_ff;
   bapst_pkg::btn_type req_item;

   // output register
   logic       out_valid_ff;
   logic [7:0] pedal_level_ff;
   logic       pedal_written_ff;
   logic [7:0] steer_level_ff;
   logic       steer_written_ff;
   logic       shift_out_ff;
   logic       brake_out_ff;

   // tick results from the channel logic
   logic [7:0] pedal_level_in;
   logic       pedal_written_in;
   logic [7:0] steer_level_in;
   logic       steer_written_in;
   logic       shift_out_in;

   logic advance;
   logic req_take;

   // a tick is processed when its result has somewhere to go
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign req_item = '{accel: req_accel_button,
                       shift: req_shift_button,
                       brake: req_brake_button,
                       up:    req_up_button,
                       down:  req_down_button,
                       left:  req_left_button,
                       right: req_right_button};

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pedal_min          <= bapst_pkg::PEDAL_MIN_RESET;
         cfg_ff.pedal_max          <= bapst_pkg::PEDAL_MAX_RESET;
         cfg_ff.steer_min          <= bapst_pkg::STEER_MIN_RESET;
         cfg_ff.steer_max          <= bapst_pkg::STEER_MAX_RESET;
         cfg_ff.steer_center       <= bapst_pkg::STEER_CENTER_RESET;
         cfg_ff.debounce_ticks     <= bapst_pkg::DEBOUNCE_RESET;
         cfg_ff.repeat_delay_ticks <= bapst_pkg::REPEAT_DELAY_RESET;
         cfg_ff.repeat_rate_ticks  <= bapst_pkg::REPEAT_RATE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            bapst_pkg::CSR_PEDAL_MIN:    cfg_ff.pedal_min          <= csr_data[7:0];
            bapst_pkg::CSR_PEDAL_MAX:    cfg_ff.pedal_max          <= csr_data[7:0];
            bapst_pkg::CSR_STEER_MIN:    cfg_ff.steer_min          <= csr_data[7:0];
            bapst_pkg::CSR_STEER_MAX:    cfg_ff.steer_max          <= csr_data[7:0];
            bapst_pkg::CSR_STEER_CENTER: cfg_ff.steer_center       <= csr_data[7:0];
            bapst_pkg::CSR_DEBOUNCE:     cfg_ff.debounce_ticks     <= csr_data;
            bapst_pkg::CSR_REPEAT_DELAY: cfg_ff.repeat_delay_ticks <= csr_data;
            bapst_pkg::CSR_REPEAT_RATE:  cfg_ff.repeat_rate_ticks  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // input register: refills as soon as its item moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
   end

   // pedal target, ramp and adjust buttons
   bapst_pedal #(.TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)) u_pedal (
      .clock      (clock),
      .reset      (reset),
      .en         (advance),
      .cfg        (cfg_ff),
      .btn        (in_item_ff),
      .level_in   (pedal_level_in),
      .written_in (pedal_written_in)
   );

   // shift debounce and toggle
   bapst_shift #(.TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)) u_shift (
      .clock          (clock),
      .reset          (reset),
      .en             (advance),
      .debounce_ticks (cfg_ff.debounce_ticks),
      .shift          (in_item_ff.shift),
      .pin_in         (shift_out_in)
   );

   // steering
   bapst_steer u_steer (
      .clock      (clock),
      .reset      (reset),
      .en         (advance),
      .cfg        (cfg_ff),
      .left       (in_item_ff.left),
      .right      (in_item_ff.right),
      .level_in   (steer_level_in),
      .written_in (steer_written_in)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pedal_level_ff   <= pedal_level_in;
         pedal_written_ff <= pedal_written_in;
         steer_level_ff   <= steer_level_in;
         steer_written_ff <= steer_written_in;
         shift_out_ff     <= shift_out_in;
         // brake pin follows its button
         brake_out_ff     <= in_item_ff.brake;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pedal_level   = pedal_level_ff;
   assign rsp_pedal_written = pedal_written_ff;
   assign rsp_steer_level   = steer_level_ff;
   assign rsp_steer_written = steer_written_ff;
   assign rsp_shift_out     = shift_out_ff;
   assign rsp_brake_out     = brake_out_ff;

endmodule
